@@ hw/rtl/sliding_window_median_filter_defines.svh @@
// assertion macros for the sliding window median filter checker
// no dependencies; the including scope must provide i_clk and i_rst_n
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SWMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define SWMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/swmf_pkg.sv @@
// shared types and constants for the sliding window median filter
// no dependencies
package swmf_pkg;

    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_WIDTH        = 7;
    localparam int WIN_RESET        = 3;

    // per-step control broadcast to every sort cell
    typedef struct packed {
        logic update;   // an input transfer happens this cycle
        logic remove;   // window full: oldest sample leaves
    } t_cell_ctrl;

endpackage

@@ hw/rtl/swmf_if.sv @@
// valid/ready channel interfaces for sample input and median output
// depends on swmf_pkg
interface swmf_in_if import swmf_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swmf_out_if import swmf_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

@@ hw/rtl/swmf_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module swmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/swmf_cell.sv @@
// one sort cell: holds one key of the ascending window store
// depends on swmf_pkg; neighbors are wired up by the top level
module swmf_cell import swmf_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int CNT_W        = 7,
    parameter int IDX          = 0
) (
    input  logic                           i_clk,
    input  t_cell_ctrl                     i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_new_key,
    input  logic signed [SAMPLE_WIDTH-1:0] i_old_key,
    input  logic [CNT_W-1:0]               i_a_cnt,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right_key,
    input  logic signed [SAMPLE_WIDTH-1:0] i_left_a,
    input  logic                           i_left_le,
    output logic signed [SAMPLE_WIDTH-1:0] o_key,
    output logic signed [SAMPLE_WIDTH-1:0] o_a,
    output logic                           o_a_le
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic signed [SAMPLE_WIDTH-1:0] r_key;
    logic signed [SAMPLE_WIDTH-1:0] n_key;
    logic                           keep;
    logic signed [SAMPLE_WIDTH-1:0] a_key;
    logic                           a_le;

    // after removal: cells below the leaving key stay, the rest close up
    assign keep  = !i_ctrl.remove || (r_key < i_old_key);
    assign a_key = keep ? r_key : i_right_key;
    assign a_le  = (IDX_C < i_a_cnt) && (a_key <= i_new_key);

    // insertion: new key goes at the first slot above all keys <= it
    assign n_key = a_le ? a_key : (i_left_le ? i_new_key : i_left_a);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.update) begin
            r_key <= n_key;
        end
    end

    assign o_key  = r_key;
    assign o_a    = a_key;
    assign o_a_le = a_le;

endmodule

@@ hw/rtl/sliding_window_median_filter.sv @@
// Streaming lower-median filter over the last window_size signed samples. A sample is taken
// on each transfer on i_in; once window_size samples have arrived since reset or the last
// write of window_size, every transfer yields one result on o_out: the element at ascending
// index (window_size-1)/2 of the current window, the new sample included. The window is held
// twice: in arrival order in a ring ram, and in ascending order in a row of MAX_WINDOW sort
// cells, where each cell updates from its own key and its two neighbors (oldest key
// removed, new key inserted, in the same update). Throughput is one sample per clock while
// i_in.ready is high; once the output register is free, the median is picked from the
// updated cells and registered there. i_in.ready drops only while a result is waiting
// in the output register that o_out has not taken and another is pending behind it.
// A window_size of zero acts as one; values above MAX_WINDOW saturate. Writing window_size
// (i_cfg_we) empties the window; write it only while no result is in flight.
// depends on swmf_pkg, swmf_if, swmf_ram, swmf_cell
module sliding_window_median_filter import swmf_pkg::*; #(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_WIDTH-1:0] i_cfg_wdata,
    swmf_in_if.sink              i_in,
    swmf_out_if.source           o_out
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int EW    = (CFG_WIDTH > CNT_W) ? CFG_WIDTH : CNT_W;
    localparam int WIN_RST = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;
    localparam int MID_RST = (WIN_RST - 1) / 2;

    // window control
    logic [CNT_W-1:0]      r_win;
    logic [MAX_WINDOW-1:0] r_mid_sel;     // one-hot: cell holding the median
    logic [CNT_W-1:0]      r_cnt;         // samples in the window
    logic [PTR_W-1:0]      r_ptr;         // ring slot of the oldest sample when full
    logic [CNT_W-1:0]      n_cnt;
    logic [PTR_W-1:0]      n_ptr;

    // config decode
    logic [EW-1:0]         cfg_ext;
    logic [CNT_W-1:0]      cfg_eff;
    logic [CNT_W-1:0]      cfg_mid;
    logic [MAX_WINDOW-1:0] cfg_mid_sel;

    // step control
    logic             in_acc;
    logic             in_ready;
    logic             full;
    logic [CNT_W-1:0] a_cnt;
    logic [CNT_W-1:0] ptr_inc;
    t_cell_ctrl       cell_ctrl;

    // ring read with write-to-read bypass
    logic signed [SAMPLE_WIDTH-1:0] ram_q;
    logic                           r_byp;
    logic signed [SAMPLE_WIDTH-1:0] r_byp_data;
    logic signed [SAMPLE_WIDTH-1:0] old_key;

    // result path
    logic                           r_pend;
    logic                           r_out_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_out;
    logic                           capture;
    logic signed [SAMPLE_WIDTH-1:0] mid_key;

    // cell row wiring
    logic signed [SAMPLE_WIDTH-1:0] cell_key [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] cell_a   [MAX_WINDOW];
    logic                           cell_le  [MAX_WINDOW];

    // window size: zero acts as one, large values saturate
    assign cfg_ext = EW'(i_cfg_wdata);
    always_comb begin
        if (cfg_ext == '0) begin
            cfg_eff = CNT_W'(1);
        end else if (cfg_ext > EW'(MAX_WINDOW)) begin
            cfg_eff = CNT_W'(MAX_WINDOW);
        end else begin
            cfg_eff = CNT_W'(cfg_ext);
        end
    end
    assign cfg_mid = (cfg_eff - CNT_W'(1)) >> 1;

    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            cfg_mid_sel[i] = (CNT_W'(i) == cfg_mid);
        end
    end

    // handshake: cells may be overwritten once the pending median is captured
    assign capture  = r_pend && (!r_out_vld || o_out.ready);
    assign in_ready = !r_pend || capture;
    assign in_acc   = i_in.valid && in_ready;

    assign full    = (r_cnt >= r_win);
    assign a_cnt   = full ? (r_cnt - CNT_W'(1)) : r_cnt;
    assign ptr_inc = CNT_W'(r_ptr) + CNT_W'(1);

    always_comb begin
        n_cnt = r_cnt;
        n_ptr = r_ptr;
        if (i_cfg_we) begin
            n_cnt = '0;
            n_ptr = '0;
        end else if (in_acc) begin
            n_cnt = full ? r_cnt : (r_cnt + CNT_W'(1));
            n_ptr = (ptr_inc >= r_win) ? '0 : PTR_W'(ptr_inc);
        end
    end

    assign cell_ctrl.update = in_acc;
    assign cell_ctrl.remove = full;

    // oldest sample: read at the next pointer every cycle, ready for the next transfer
    swmf_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW),
        .AW    (PTR_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_ptr),
        .i_wdata (i_in.sample),
        .i_raddr (n_ptr),
        .o_rdata (ram_q)
    );

    // a one-sample window reads back the slot written at the same edge
    assign old_key = r_byp ? r_byp_data : ram_q;

    // sorted cell row
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] right_key;
        logic signed [SAMPLE_WIDTH-1:0] left_a;
        logic                           left_le;

        if (g == MAX_WINDOW - 1) begin : g_last
            assign right_key = '0;
        end else begin : g_mid
            assign right_key = cell_key[g + 1];
        end

        if (g == 0) begin : g_first
            assign left_a  = '0;
            assign left_le = 1'b1;
        end else begin : g_rest
            assign left_a  = cell_a[g - 1];
            assign left_le = cell_le[g - 1];
        end

        swmf_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .CNT_W        (CNT_W),
            .IDX          (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl),
            .i_new_key   (i_in.sample),
            .i_old_key   (old_key),
            .i_a_cnt     (a_cnt),
            .i_right_key (right_key),
            .i_left_a    (left_a),
            .i_left_le   (left_le),
            .o_key       (cell_key[g]),
            .o_a         (cell_a[g]),
            .o_a_le      (cell_le[g])
        );
    end

    // median pick from the settled cells
    always_comb begin
        mid_key = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            mid_key = mid_key | (cell_key[i] & {SAMPLE_WIDTH{r_mid_sel[i]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= CNT_W'(WIN_RST);
            r_mid_sel <= MAX_WINDOW'(1) << MID_RST;
            r_cnt     <= '0;
            r_ptr     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            r_byp     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win     <= cfg_eff;
                r_mid_sel <= cfg_mid_sel;
            end
            r_cnt <= n_cnt;
            r_ptr <= n_ptr;
            r_byp <= in_acc && (n_ptr == r_ptr);
            // pending median: set by a transfer that leaves the window full
            if (in_acc) begin
                r_pend <= (n_cnt >= r_win);
            end else if (capture) begin
                r_pend <= 1'b0;
            end
            if (capture) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_in.sample;
        if (capture) begin
            r_out <= mid_key;
        end
    end

    assign i_in.ready   = in_ready;
    assign o_out.valid  = r_out_vld;
    assign o_out.median = r_out;

endmodule

@@ hw/rtl/swmf_checker.sv @@
// port-level checker for the sliding window median filter, bound to the top level
// depends on sliding_window_median_filter_defines.svh
`include "sliding_window_median_filter_defines.svh"

module swmf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // a stalled result stays offered
    `SWMF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // a new result follows an input transfer, via the pending flag and the output register
    `SWMF_ASSERT_NOW(a_out_cause, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 2), "result without input transfer")

    // input back-pressure only comes from a stalled output
    `SWMF_ASSERT_NOW(a_in_stall, !i_in_ready, i_out_valid && !i_out_ready, "input stalled with free output")

    // output register comes out of reset empty
    `SWMF_ASSERT_NOW(a_rst_empty, $past(!i_rst_n), !i_out_valid, "result valid right after reset")

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

@@ tb/sliding_window_median_filter_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench for sliding_window_median_filter: directed table, then random phases
// with bursty input and a stalling receiver, each median checked against a typed-in value or a local predictor
// depends on swmf_pkg, swmf_if and the filter rtl
module sliding_window_median_filter_test;
    import swmf_pkg::*;

    typedef logic signed [SAMPLE_WIDTH_DEF-1:0] t_sample;

    // directed table rows: a window write, or a sample with an optional typed-in median
    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;
    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_WIDTH-1:0] cfg_value;
        t_sample              value;
        logic                 pinned;
        t_sample              pinned_median;
    } t_step_row;

    // receiver stall styles, redrawn at random by the receiver from its own tick counter
    typedef enum {RX_STREAM, RX_COIN, RX_PERIODIC, RX_LONG} t_rx_mode;

    localparam int      RANDOM_ITEMS = 1700;
    localparam int      SETTLE_CYCLES = 8;
    localparam t_sample S_MIN = 32'h8000_0000;
    localparam t_sample S_MAX = 32'h7fff_ffff;

    localparam t_step_row DIRECTED [25] = '{
        // reset window of 3, first result on the third sample
        '{ROW_SAMPLE, 7'd0, 32'sd5, 1'b0, 32'sd0},
        '{ROW_SAMPLE, 7'd0, -32'sd7, 1'b0, 32'sd0},
        '{ROW_SAMPLE, 7'd0, 32'sd100, 1'b1, 32'sd5},
        '{ROW_SAMPLE, 7'd0, S_MAX, 1'b1, 32'sd100},
        '{ROW_SAMPLE, 7'd0, S_MIN, 1'b1, 32'sd100},
        // window of one passes samples straight through, extremes included
        '{ROW_CFG, 7'd1, 32'sd0, 1'b0, 32'sd0},
        '{ROW_SAMPLE, 7'd0, S_MIN, 1'b1, S_MIN},
        '{ROW_SAMPLE, 7'd0, S_MAX, 1'b1, S_MAX},
        '{ROW_SAMPLE, 7'd0, 32'sd0, 1'b1, 32'sd0},
        '{ROW_SAMPLE, 7'd0, -32'sd1, 1'b1, -32'sd1},
        // zero window behaves as one
        '{ROW_CFG, 7'd0, 32'sd0, 1'b0, 32'sd0},
        '{ROW_SAMPLE, 7'd0, 32'sd42, 1'b1, 32'sd42},
        '{ROW_SAMPLE, 7'd0, -32'sd42, 1'b1, -32'sd42},
        // even window picks the lower of the two middle values
        '{ROW_CFG, 7'd2, 32'sd0, 1'b0, 32'sd0},
        '{ROW_SAMPLE, 7'd0, 32'sd10, 1'b0, 32'sd0},
        '{ROW_SAMPLE, 7'd0, 32'sd20, 1'b1, 32'sd10},
        '{ROW_SAMPLE, 7'd0, 32'sd20, 1'b1, 32'sd20},
        '{ROW_SAMPLE, 7'd0, 32'sd10, 1'b1, 32'sd10},
        // duplicates: only one copy of the leaving value goes
        '{ROW_CFG, 7'd4, 32'sd0, 1'b0, 32'sd0},
        '{ROW_SAMPLE, 7'd0, 32'sd7, 1'b0, 32'sd0},
        '{ROW_SAMPLE, 7'd0, 32'sd7, 1'b0, 32'sd0},
        '{ROW_SAMPLE, 7'd0, 32'sd7, 1'b0, 32'sd0},
        '{ROW_SAMPLE, 7'd0, 32'sd3, 1'b1, 32'sd7},
        '{ROW_SAMPLE, 7'd0, 32'sd9, 1'b1, 32'sd7},
        '{ROW_SAMPLE, 7'd0, 32'sd1, 1'b1, 32'sd3}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_WIDTH-1:0] i_cfg_wdata;

    swmf_in_if  in_ch ();
    swmf_out_if out_ch ();

    sliding_window_median_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // predictor state: the configured window and the samples inside it, oldest first
    logic [CFG_WIDTH-1:0] window_cfg;
    t_sample              recent_samples[$];
    t_sample              pending_medians[$];
    int                   error_count = 0;

    // a typed-in median for the sample now being offered, set by the sender
    logic    pin_armed = 1'b0;
    t_sample pin_median = '0;

    // sender burst bookkeeping
    int burst_left = 0;
    bit steady_feed = 1'b0;

    // receiver stall bookkeeping
    t_rx_mode rx_mode = RX_STREAM;
    int       rx_tick = 0;
    int       rx_hold = 0;

    always #2 i_clk = ~i_clk;

    // add a sample to the window; returns 1 with the lower median once the window is full
    function automatic bit take_sample(input t_sample s, output t_sample med);
        int span;
        int rank;
        int lt;
        int le;
        span = (window_cfg == 0) ? 1 :
               (window_cfg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(window_cfg);
        med = '0;
        // full window: the oldest sample leaves before the new one enters
        if (recent_samples.size() >= span) void'(recent_samples.pop_front());
        recent_samples.push_back(s);
        if (recent_samples.size() < span) return 1'b0;
        rank = (span - 1) / 2;
        // a value sits at the rank if fewer than rank+1 are below it and more than rank
        // are at or below it
        foreach (recent_samples[i]) begin
            lt = 0;
            le = 0;
            foreach (recent_samples[j]) begin
                if (recent_samples[j] < recent_samples[i]) lt++;
                if (recent_samples[j] <= recent_samples[i]) le++;
            end
            if (lt <= rank && rank < le) med = recent_samples[i];
        end
        return 1'b1;
    endfunction

    // sampling and checking, all on the rising edge
    always @(posedge i_clk) begin
        t_sample predicted;
        t_sample expected;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_medians.size() == 0) begin
                    $display("%0t: unexpected median, expected none, got %0d",
                             $time, out_ch.median);
                    error_count++;
                end else begin
                    expected = pending_medians.pop_front();
                    if (out_ch.median !== expected) begin
                        $display("%0t: median mismatch, expected %0d, got %0d",
                                 $time, expected, out_ch.median);
                        error_count++;
                    end
                end
            end
            // a window write empties the window
            if (i_cfg_we) begin
                window_cfg = i_cfg_wdata;
                recent_samples.delete();
            end
            if (in_ch.valid && in_ch.ready) begin
                if (take_sample(in_ch.sample, predicted))
                    pending_medians.push_back(pin_armed ? pin_median : predicted);
            end
        end
    end

    // receiver: stall pattern of its own, changed at the falling edge
    always @(negedge i_clk) begin
        rx_tick++;
        if (rx_tick % 256 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_STREAM: begin
                out_ch.ready <= 1'b1;
            end
            RX_COIN: begin
                out_ch.ready <= 1'($urandom_range(0, 1));
            end
            RX_PERIODIC: begin
                out_ch.ready <= (rx_tick % 4 == 0);
            end
            default: begin
                // long stalls now and then
                if (rx_hold > 0) begin
                    rx_hold--;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 20);
                end
            end
        endcase
    end

    // offer one sample and hold it until its transfer; called and returns at a falling edge
    task automatic send_sample(input t_sample value, input logic pinned,
                               input t_sample pinned_median);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = steady_feed ? 0 : $urandom_range(0, 7);
            // valid only drops when a real gap follows
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        pin_armed  = pinned;
        pin_median = pinned_median;
        in_ch.valid  <= 1'b1;
        in_ch.sample <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // write the window size once the filter has gone idle
    task automatic set_window(input logic [CFG_WIDTH-1:0] value);
        in_ch.valid <= 1'b0;
        while (pending_medians.size() != 0) @(negedge i_clk);
        // samples still filling the window leave nothing in the queue, so let the pipe drain
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [CFG_WIDTH-1:0] win;
        int                   span;
        int                   count;
        int                   sent;
        t_sample              value;

        // every input known from time zero
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
        window_cfg   = CFG_WIDTH'(WIN_RESET);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_CFG)
                set_window(DIRECTED[r].cfg_value);
            else
                send_sample(DIRECTED[r].value, DIRECTED[r].pinned, DIRECTED[r].pinned_median);
        end

        // random phases: mostly small windows, some full-size and saturating ones
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       win = 7'd0;
                1:       win = 7'd64;
                2:       win = 7'd127;
                3:       win = CFG_WIDTH'($urandom_range(65, 126));
                4:       win = 7'd1;
                default: win = CFG_WIDTH'($urandom_range(2, 12));
            endcase
            span  = (win == 0) ? 1 : (win > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(win);
            count = span + $urandom_range(0, 40);
            steady_feed = ($urandom_range(0, 3) == 0);
            set_window(win);
            repeat (count) begin
                // mix of full-range values, extremes and a narrow band that forces duplicates
                case ($urandom_range(0, 9))
                    0:       value = $urandom_range(0, 1) ? S_MIN : S_MAX;
                    1, 2, 3: value = t_sample'($urandom_range(0, 8)) - 32'sd4;
                    default: value = t_sample'($urandom);
                endcase
                send_sample(value, 1'b0, '0);
                sent++;
            end
        end

        // drain and give stray results a chance to show up
        in_ch.valid <= 1'b0;
        while (pending_medians.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        if (error_count == 0)
            $display("sliding_window_median_filter_test: clean");
        else
            $display("sliding_window_median_filter_test: errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("sliding_window_median_filter_test: errors");
        $finish;
    end

endmodule
